/* rtl/core/i2da_pkg.sv */
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants of the integer to decimal text converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

  // ASCII codes of the characters that the converter emits.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;

  // A 32-bit magnitude has at most ten decimal digits.
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigIdxW   = $clog2(MaxDigits);

  // Reciprocal of ten: floor(x * RecipTen / 2^RecipShift) == x / 10 for any 32-bit x.
  localparam logic [31:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  // A classified item: sign and unsigned magnitude.
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } cls_t;

endpackage

/* rtl/core/i2da_if.sv */
// ----------------------------------------------------------------------------
// i2da_if
// Valid/ready channels of the converter: the value input and the text output.
// ----------------------------------------------------------------------------
interface i2da_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2da_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

/* rtl/core/i2da_front.sv */
// ----------------------------------------------------------------------------
// i2da_front
// Accepts value items, splits each into sign and magnitude, and holds the
// result in a register until the queue takes it.
// ----------------------------------------------------------------------------
module i2da_front import i2da_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  i2da_in_if.sink         in_i,
  output cls_t            cls_o,
  output logic            cls_valid_o,
  input  logic            cls_ready_i
);

  logic valid_q, valid_d;
  cls_t cls_q, cls_d;
  logic accept;

  // The holding register frees up as soon as its item moves on.
  assign in_i.ready = !valid_q || cls_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // Magnitude in unsigned arithmetic, so the most negative value maps to 2^31.
  always_comb begin
    cls_d.neg = in_i.value[31];
    cls_d.mag = in_i.value[31] ? (32'd0 - unsigned'(in_i.value)) : unsigned'(in_i.value);
    valid_d   = accept ? 1'b1 : (cls_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

  assign cls_o       = cls_q;
  assign cls_valid_o = valid_q;

endmodule

/* rtl/core/i2da_fifo.sv */
// ----------------------------------------------------------------------------
// i2da_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module i2da_fifo import i2da_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cls_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output cls_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cls_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/i2da_back.sv */
// ----------------------------------------------------------------------------
// i2da_back
// Splits a magnitude into decimal digits, one divide by ten per cycle, then
// emits the sign and the digits most significant first through an output
// register.
// ----------------------------------------------------------------------------
module i2da_back import i2da_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cls_t        cls_i,
  input  logic        cls_valid_i,
  output logic        cls_ready_o,
  i2da_out_if.source  out_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  state_e             state_q;
  logic [31:0]        mag_q;
  logic               neg_q;
  logic [DigIdxW-1:0] nd_q;
  logic [DigIdxW-1:0] idx_q;
  logic [3:0]         dig_q [MaxDigits];
  logic               ov_q;
  logic [7:0]         char_q;
  logic               last_q;

  logic [63:0]        prod;
  logic [31:0]        quo;
  logic [31:0]        quo_ten;
  logic [31:0]        rem;
  logic               out_free;

  // Divide by ten through the reciprocal; the remainder comes from a shift-add.
  assign prod    = {32'd0, mag_q} * {32'd0, RecipTen};
  assign quo     = {{RecipShift - 32{1'b0}}, prod[63:RecipShift]};
  assign quo_ten = {quo[28:0], 3'b000} + {quo[30:0], 1'b0};
  assign rem     = mag_q - quo_ten;

  assign out_free    = !ov_q || out_o.ready;
  assign cls_ready_o = (state_q == StIdle);

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      neg_q   <= 1'b0;
      nd_q    <= '0;
      idx_q   <= '0;
      mag_q   <= '0;
      char_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (out_o.ready) begin
            ov_q <= 1'b0;
          end
          if (cls_valid_i) begin
            mag_q   <= cls_i.mag;
            neg_q   <= cls_i.neg;
            nd_q    <= '0;
            state_q <= StConv;
          end
        end
        StConv: begin
          if (out_o.ready) begin
            ov_q <= 1'b0;
          end
          mag_q <= quo;
          if (quo == 32'd0 || nd_q == DigIdxW'(MaxDigits - 1)) begin
            idx_q   <= nd_q;
            state_q <= StEmit;
          end else begin
            nd_q <= nd_q + 1'b1;
          end
        end
        StEmit: begin
          if (out_free) begin
            ov_q <= 1'b1;
            if (neg_q) begin
              char_q <= CharMinus;
              last_q <= 1'b0;
              neg_q  <= 1'b0;
            end else begin
              char_q <= CharZero + {4'd0, dig_q[idx_q]};
              last_q <= (idx_q == '0);
              if (idx_q == '0) begin
                state_q <= StIdle;
              end else begin
                idx_q <= idx_q - 1'b1;
              end
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Digit buffer, filled least significant first.
  always_ff @(posedge clk_i) begin
    if (state_q == StConv) begin
      dig_q[nd_q] <= rem[3:0];
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

endmodule

/* rtl/core/int32_to_decimal_ascii.sv */
// Path: an accepted value passes through the front holding register and the
// queue to the back, which finds its d (1 to 10) decimal digits one per cycle.
// Items: the back emits n characters (d, plus one for a sign) through its
// single output register, which stalls while out_o.ready is low, and takes
// a new item only when idle, once the last character is in that register.
// Reset: rst_ni clears the queue, the sequencer and the output valid at once.
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// Converts signed 32-bit values into decimal ASCII text with a last mark,
// through a classifying front, a short queue and a digit-generating back.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii import i2da_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2da_in_if.sink     in_i,
  i2da_out_if.source  out_o
);

  cls_t front_cls;
  logic front_valid;
  logic front_ready;
  cls_t back_cls;
  logic back_valid;
  logic back_ready;

  // Front: accept and classify.
  i2da_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cls_o       (front_cls),
    .cls_valid_o (front_valid),
    .cls_ready_i (front_ready)
  );

  // Queue between the two sides.
  i2da_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cls),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cls),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // Back: digit generation and emission.
  i2da_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (back_cls),
    .cls_valid_i (back_valid),
    .cls_ready_o (back_ready),
    .out_o       (out_o)
  );

  // A minus sign never closes a number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.character == CharMinus |-> !out_o.last)
    else $error("minus sign marked as last character");

  // The closing character is always a digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> out_o.character >= CharZero && out_o.character <= CharNine)
    else $error("last character is not a digit");

  // A minus sign is never followed by a second minus sign.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.character == CharMinus |=>
      !(out_o.valid && out_o.character == CharMinus))
    else $error("two minus signs in a row");

endmodule
